[hdl/sui_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sui_pkg
// Shared types and constants for the sorted unique insertion store.
// ----------------------------------------------------------------------------
package sui_pkg;

   localparam int VAL_W           = 32;
   localparam int EPS_W           = 31;
   localparam int CNT_W           = 7;
   localparam int MAX_ENTRIES_DEF = 64;

   localparam logic [EPS_W-1:0] EPS_RESET = EPS_W'(66);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_UPDATE,
      ST_EMIT
   } sui_state_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic scan;
      logic update;
      logic emit_load;
   } sui_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic last_item;
      logic fill_zero;
      logic fill_one;
   } sui_status_type;

endpackage

[hdl/sui_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sui_ctrl
// Sequencer: accept an item, scan the store, update it, and drain the list
// into the output register on the last item.
// ----------------------------------------------------------------------------
module sui_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  sui_pkg::sui_status_type status,
   output sui_pkg::sui_cmd_type    cmd
);

   sui_pkg::sui_state_type state_ff, state_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   can_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sui_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign can_load = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      req_ready     = 1'b0;
      unique case (state_ff)
         sui_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = sui_pkg::ST_SCAN;
            end
         end
         sui_pkg::ST_SCAN: begin
            cmd.scan = 1'b1;
            state_in = sui_pkg::ST_UPDATE;
         end
         sui_pkg::ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = status.last_item ? sui_pkg::ST_EMIT : sui_pkg::ST_IDLE;
         end
         sui_pkg::ST_EMIT: begin
            if (status.fill_zero) begin
               state_in = sui_pkg::ST_IDLE;
            end else if (can_load) begin
               cmd.emit_load = 1'b1;
               if (status.fill_one) begin
                  state_in = sui_pkg::ST_IDLE;
               end
            end
         end
         default: state_in = sui_pkg::ST_IDLE;
      endcase
   end

   // hold the result until it is taken
   always_comb begin
      if (cmd.emit_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

[hdl/sui_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sui_datapath
// Row of value cells with per-cell compare, neighbor select, tolerance check,
// shift-up insert and shift-down drain into the output register.
// ----------------------------------------------------------------------------
module sui_datapath #(
   parameter int MAX_ENTRIES = sui_pkg::MAX_ENTRIES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  sui_pkg::sui_cmd_type              cmd,
   output sui_pkg::sui_status_type           status,
   input  logic                              csr_wr_en,
   input  logic [sui_pkg::EPS_W-1:0]         csr_wr_data,
   input  logic signed [sui_pkg::VAL_W-1:0]  req_sample_value,
   input  logic                              req_last_item,
   output logic signed [sui_pkg::VAL_W-1:0]  rsp_out_value,
   output logic                              rsp_out_last,
   output logic [sui_pkg::CNT_W-1:0]         rsp_kept_total,
   output logic                              rsp_overflowed
);

   logic signed [sui_pkg::VAL_W-1:0] cells_ff [MAX_ENTRIES];
   logic signed [sui_pkg::VAL_W-1:0] cells_in [MAX_ENTRIES];
   logic signed [sui_pkg::VAL_W-1:0] prev_cell [MAX_ENTRIES];
   logic signed [sui_pkg::VAL_W-1:0] next_cell [MAX_ENTRIES];

   logic signed [sui_pkg::VAL_W-1:0] sample_ff;
   logic                             last_ff;
   logic [sui_pkg::CNT_W-1:0]        fill_ff, fill_in;
   logic                             ovf_ff, ovf_in;
   logic [sui_pkg::CNT_W-1:0]        kept_ff;
   logic [sui_pkg::EPS_W-1:0]        eps_ff;

   logic [MAX_ENTRIES-1:0]           le;
   logic [MAX_ENTRIES-1:0]           le_up;
   logic [MAX_ENTRIES-1:0]           le_ff_dn;
   logic [MAX_ENTRIES-1:0]           nb_flag;
   logic [MAX_ENTRIES-1:0]           le_ff;
   logic [MAX_ENTRIES-1:0]           nb_flag_ff;
   logic signed [sui_pkg::VAL_W-1:0] nb_mux;
   logic signed [sui_pkg::VAL_W-1:0] nb_value_ff;

   logic [sui_pkg::VAL_W:0]          diff;
   logic                             merge;
   logic                             full;
   logic                             do_insert;

   logic signed [sui_pkg::VAL_W-1:0] out_value_ff;
   logic                             out_last_ff;
   logic [sui_pkg::CNT_W-1:0]        out_kept_ff;
   logic                             out_ovf_ff;

   // per-cell compare and neighbor wiring
   for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
      assign le[i] = (sui_pkg::CNT_W'(i) < fill_ff) && (cells_ff[i] <= sample_ff);
      if (i == MAX_ENTRIES - 1) begin : g_top
         assign le_up[i]     = 1'b0;
         assign next_cell[i] = cells_ff[i];
      end else begin : g_mid
         assign le_up[i]     = le[i+1];
         assign next_cell[i] = cells_ff[i+1];
      end
      if (i == 0) begin : g_bot
         assign le_ff_dn[i]  = 1'b1;
         assign prev_cell[i] = sample_ff;
      end else begin : g_up
         assign le_ff_dn[i]  = le_ff[i-1];
         assign prev_cell[i] = cells_ff[i-1];
      end
      // the last cell not greater than the new value
      assign nb_flag[i] = le[i] && !le_up[i];

      always_comb begin
         cells_in[i] = cells_ff[i];
         if (cmd.emit_load) begin
            cells_in[i] = next_cell[i];
         end else if (cmd.update) begin
            if (merge) begin
               if (nb_flag_ff[i]) begin
                  cells_in[i] = sample_ff;
               end
            end else if (!full && !le_ff[i]) begin
               // first cell above the insert point takes the value, rest shift up
               cells_in[i] = le_ff_dn[i] ? sample_ff : prev_cell[i];
            end
         end
      end
   end

   always_comb begin
      nb_mux = '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         nb_mux = nb_mux | (nb_flag[i] ? cells_ff[i] : '0);
      end
   end

   assign diff      = {sample_ff[sui_pkg::VAL_W-1], sample_ff}
                    - {nb_value_ff[sui_pkg::VAL_W-1], nb_value_ff};
   assign merge     = le_ff[0] && (diff < {2'b00, eps_ff});
   assign full      = (fill_ff == sui_pkg::CNT_W'(MAX_ENTRIES));
   assign do_insert = cmd.update && !merge && !full;

   always_comb begin
      fill_in = fill_ff;
      if (do_insert) begin
         fill_in = fill_ff + sui_pkg::CNT_W'(1);
      end else if (cmd.emit_load) begin
         fill_in = fill_ff - sui_pkg::CNT_W'(1);
      end
   end

   always_comb begin
      ovf_in = ovf_ff;
      if (cmd.update && !merge && full) begin
         ovf_in = 1'b1;
      end else if (cmd.emit_load && status.fill_one) begin
         ovf_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         ovf_ff  <= 1'b0;
         eps_ff  <= sui_pkg::EPS_RESET;
      end else begin
         fill_ff <= fill_in;
         ovf_ff  <= ovf_in;
         if (csr_wr_en) begin
            eps_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      cells_ff <= cells_in;
      if (cmd.load) begin
         sample_ff <= req_sample_value;
         last_ff   <= req_last_item;
      end
      if (cmd.scan) begin
         le_ff       <= le;
         nb_flag_ff  <= nb_flag;
         nb_value_ff <= nb_mux;
      end
      if (cmd.update) begin
         kept_ff <= fill_in;
      end
      if (cmd.emit_load) begin
         out_value_ff <= cells_ff[0];
         out_last_ff  <= status.fill_one;
         out_kept_ff  <= kept_ff;
         out_ovf_ff   <= ovf_ff;
      end
   end

   assign status.last_item = last_ff;
   assign status.fill_zero = (fill_ff == '0);
   assign status.fill_one  = (fill_ff == sui_pkg::CNT_W'(1));

   assign rsp_out_value  = out_value_ff;
   assign rsp_out_last   = out_last_ff;
   assign rsp_kept_total = out_kept_ff;
   assign rsp_overflowed = out_ovf_ff;

endmodule

[hdl/sorted_unique_insertion.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_unique_insertion
// Keeps signed Q16.16 values in ascending order, merges near duplicates and
// drains the sorted list when the last item of a list arrives.
// ----------------------------------------------------------------------------
// Usage:
//   req_* channel carries one value per item plus a last-of-list flag.
//   rsp_* channel returns the stored values in ascending order, one per
//   item, only after the last input item; out_last marks the final one,
//   kept_total and overflowed are the same on every item of the list.
//   csr_wr_en / csr_wr_data write the duplicate tolerance (reset 66).
// Timing:
//   An item passes three steps (accept, compare across all cells, update the
//   cell row), and a new item is taken only after the last one is through.
//   On a last item the list then drains one item per cycle through the
//   output register while the receiver does not stall.
// Reset clears the fill count, overflow flag and output valid; cell
// contents are left as they are. A stalled receiver holds the output
// register and pauses the drain; the next item is taken once the final
// result sits in the output register.
// ----------------------------------------------------------------------------
module sorted_unique_insertion #(
   parameter int MAX_ENTRIES = sui_pkg::MAX_ENTRIES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [sui_pkg::EPS_W-1:0]         csr_wr_data,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic signed [sui_pkg::VAL_W-1:0]  req_sample_value,
   input  logic                              req_last_item,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [sui_pkg::VAL_W-1:0]  rsp_out_value,
   output logic                              rsp_out_last,
   output logic [sui_pkg::CNT_W-1:0]         rsp_kept_total,
   output logic                              rsp_overflowed
);

   sui_pkg::sui_cmd_type    cmd;
   sui_pkg::sui_status_type status;

   sui_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   sui_datapath #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_sample_value (req_sample_value),
      .req_last_item    (req_last_item),
      .rsp_out_value    (rsp_out_value),
      .rsp_out_last     (rsp_out_last),
      .rsp_kept_total   (rsp_kept_total),
      .rsp_overflowed   (rsp_overflowed)
   );

endmodule

[hdl/sui_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sui_checker
// Port-level checks for the sorted unique insertion store.
// ----------------------------------------------------------------------------
module sui_checker #(
   parameter int MAX_ENTRIES = sui_pkg::MAX_ENTRIES_DEF
) (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic signed [sui_pkg::VAL_W-1:0]  rsp_out_value,
   input logic                              rsp_out_last,
   input logic [sui_pkg::CNT_W-1:0]         rsp_kept_total
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_value)
                                  && $stable(rsp_out_last))
      else $error("result changed while stalled");

   // one item at a time
   a_req_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input taken while an item is in work");

   a_kept_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_kept_total != '0)
                    && (rsp_kept_total <= sui_pkg::CNT_W'(MAX_ENTRIES)))
      else $error("kept total out of range");

   // inside a list values do not descend and the count does not change
   a_list_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_out_last |=>
         !rsp_valid
         || (rsp_out_value >= $past(rsp_out_value)
             && rsp_kept_total == $past(rsp_kept_total)))
      else $error("list not ascending or count changed");

endmodule

bind sorted_unique_insertion sui_checker #(
   .MAX_ENTRIES (MAX_ENTRIES)
) u_sui_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_out_value  (rsp_out_value),
   .rsp_out_last   (rsp_out_last),
   .rsp_kept_total (rsp_kept_total)
);

[test/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sorted unique insertion store.
// Feeds lists of Q16.16 values over the req_ channel. A local copy of the
// insertion store predicts the sorted and merged drain of every list. Each
// rsp_ item is compared field by field with the oldest prediction. Runs
// several tolerance settings, random idling on both channels and two long
// receiver hold-offs that back the block up into its input.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int DEPTH       = sui_pkg::MAX_ENTRIES_DEF;
   localparam int STALL_LIMIT = 4000;
   localparam int LONG_HOLD   = 300;
   localparam logic [sui_pkg::EPS_W-1:0] EPS_MAX = {sui_pkg::EPS_W{1'b1}};
   localparam logic signed [sui_pkg::VAL_W-1:0] EDGE_VALS [5] =
      '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0, -32'sd1, 32'sd1};

   typedef enum int {
      SPREAD_FULL,
      SPREAD_CLUSTER,
      SPREAD_EDGES,
      SPREAD_GRID
   } spread_type;

   typedef struct {
      logic signed [sui_pkg::VAL_W-1:0] value;
      logic                             last;
   } sample_type;

   typedef struct {
      logic signed [sui_pkg::VAL_W-1:0] value;
      logic                             last;
      logic [sui_pkg::CNT_W-1:0]        kept;
      logic                             ovf;
   } drain_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             csr_wr_en = 1'b0;
   logic [sui_pkg::EPS_W-1:0]        csr_wr_data = '0;
   logic                             req_valid = 1'b0;
   logic                             req_ready;
   logic signed [sui_pkg::VAL_W-1:0] req_sample_value = '0;
   logic                             req_last_item = 1'b0;
   logic                             rsp_valid;
   logic                             rsp_ready = 1'b0;
   logic signed [sui_pkg::VAL_W-1:0] rsp_out_value;
   logic                             rsp_out_last;
   logic [sui_pkg::CNT_W-1:0]        rsp_kept_total;
   logic                             rsp_overflowed;

   sample_type pending_samples[$];
   drain_type  expected_drain[$];

   // local copy of the store
   logic signed [sui_pkg::VAL_W-1:0] model_cells [DEPTH];
   int                               model_fill = 0;
   logic                             model_ovf = 1'b0;
   logic [sui_pkg::EPS_W-1:0]        model_eps = sui_pkg::EPS_RESET;

   int   tx_idle_pct = 19;
   int   rx_idle_pct = 46;
   int   hold_requests = 0;
   int   hold_served = 0;
   int   hold_left = 0;
   int   quiet_cycles = 0;
   int   error_count = 0;
   logic req_taken = 1'b0;

   sorted_unique_insertion dut (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_sample_value (req_sample_value),
      .req_last_item    (req_last_item),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_value    (rsp_out_value),
      .rsp_out_last     (rsp_out_last),
      .rsp_kept_total   (rsp_kept_total),
      .rsp_overflowed   (rsp_overflowed)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Insert one value; on the last item of a list, queue the whole drain.
   function automatic void sort_in_sample(logic signed [sui_pkg::VAL_W-1:0] v,
                                          logic last);
      int     pos;
      longint gap;
      logic   merged;
      pos = 0;
      merged = 1'b0;
      while (pos < model_fill && model_cells[pos] <= v)
         pos++;
      if (pos > 0) begin
         gap = longint'(v) - longint'(model_cells[pos-1]);
         if (gap < longint'(model_eps)) begin
            model_cells[pos-1] = v;
            merged = 1'b1;
         end
      end
      if (!merged) begin
         if (model_fill >= DEPTH) begin
            model_ovf = 1'b1;
         end else begin
            for (int k = model_fill; k > pos; k--)
               model_cells[k] = model_cells[k-1];
            model_cells[pos] = v;
            model_fill++;
         end
      end
      if (last) begin
         for (int k = 0; k < model_fill; k++)
            expected_drain.push_back('{value: model_cells[k],
                                       last:  (k == model_fill - 1),
                                       kept:  sui_pkg::CNT_W'(model_fill),
                                       ovf:   model_ovf});
         model_fill = 0;
         model_ovf = 1'b0;
      end
   endfunction

   // Check results, run the prediction, watch for a hang.
   always @(posedge clock) begin : edge_monitor
      drain_type want;
      if (reset) begin
         req_taken <= 1'b0;
         quiet_cycles <= 0;
      end else begin
         req_taken <= req_valid && req_ready;
         if (rsp_valid && rsp_ready) begin
            if (expected_drain.size() == 0) begin
               $error("result item with nothing expected: out_value %0d", rsp_out_value);
               error_count++;
            end else begin
               want = expected_drain.pop_front();
               if (rsp_out_value !== want.value) begin
                  $error("out_value: expected %0d, got %0d", want.value, rsp_out_value);
                  error_count++;
               end
               if (rsp_out_last !== want.last) begin
                  $error("out_last: expected %0d, got %0d", want.last, rsp_out_last);
                  error_count++;
               end
               if (rsp_kept_total !== want.kept) begin
                  $error("kept_total: expected %0d, got %0d", want.kept, rsp_kept_total);
                  error_count++;
               end
               if (rsp_overflowed !== want.ovf) begin
                  $error("overflowed: expected %0d, got %0d", want.ovf, rsp_overflowed);
                  error_count++;
               end
            end
         end
         if (req_valid && req_ready)
            sort_in_sample(req_sample_value, req_last_item);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   // Sender: hold the item until taken, then offer the next one or idle.
   always @(negedge clock) begin : sender
      sample_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (pending_samples.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
            nxt = pending_samples.pop_front();
            req_valid <= 1'b1;
            req_sample_value <= nxt.value;
            req_last_item <= nxt.last;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: random stalls, plus a long hold-off on request.
   always @(negedge clock) begin : receiver
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_served != hold_requests) begin
         rsp_ready <= 1'b0;
         hold_left <= LONG_HOLD;
         hold_served <= hold_requests;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   function automatic logic signed [sui_pkg::VAL_W-1:0] pick_value(spread_type spread);
      unique case (spread)
         SPREAD_FULL:    return $urandom;
         SPREAD_CLUSTER: return $urandom_range(0, 400) - 200;
         SPREAD_EDGES:   return EDGE_VALS[$urandom_range(0, 4)];
         default:        return $urandom_range(0, 149) * 256 - 19200;
      endcase
   endfunction

   task automatic queue_sample(logic signed [sui_pkg::VAL_W-1:0] v, logic last);
      pending_samples.push_back('{value: v, last: last});
   endtask

   task automatic queue_random_list(int len, spread_type spread);
      for (int k = 0; k < len; k++)
         queue_sample(pick_value(spread), k == len - 1);
   endtask

   // Block is idle once every item is taken and every result has come back.
   task automatic wait_idle();
      while (pending_samples.size() != 0 || req_valid || expected_drain.size() != 0)
         @(posedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_tolerance(logic [sui_pkg::EPS_W-1:0] eps);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= eps;
      model_eps = eps;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic run_segment(int budget, logic [sui_pkg::EPS_W-1:0] eps,
                              logic with_fill);
      int queued;
      int len;
      queued = 0;
      write_tolerance(eps);
      if (with_fill) begin
         // stall the output while short lists back up into the input
         hold_requests++;
         budget = budget - 100;
      end
      while (queued < budget) begin
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
         queue_random_list(len, spread_type'($urandom_range(0, 3)));
         queued += len;
      end
      // long list on a coarse grid: at small tolerance it fills the store, repeats still merge
      if (with_fill)
         queue_random_list(100, SPREAD_GRID);
      wait_idle();
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // default tolerance: merges from below, equal values, extremes
      queue_sample(0, 1'b0);
      queue_sample(5, 1'b0);
      queue_sample(100, 1'b0);
      queue_sample(100, 1'b0);
      queue_sample(50, 1'b0);
      queue_sample(32'sh8000_0000, 1'b0);
      queue_sample(32'sh7FFF_FFFF, 1'b0);
      queue_sample(-1, 1'b1);
      queue_sample(12345, 1'b1);
      // new smallest value, merge into lower neighbour, near value above left alone
      queue_sample(70, 1'b0);
      queue_sample(3, 1'b0);
      queue_sample(68, 1'b0);
      queue_sample(60, 1'b0);
      queue_sample(10, 1'b1);
      wait_idle();

      // zero tolerance: equal values all kept
      write_tolerance('0);
      queue_sample(7, 1'b0);
      queue_sample(7, 1'b0);
      queue_sample(7, 1'b1);
      wait_idle();

      // widest tolerance
      write_tolerance(EPS_MAX);
      queue_sample(32'sh8000_0000, 1'b0);
      queue_sample(32'sh7FFF_FFFF, 1'b1);
      queue_sample(0, 1'b0);
      queue_sample(32'sh7FFF_FFFE, 1'b1);
      wait_idle();

      run_segment(140, sui_pkg::EPS_W'($urandom_range(1, 255)), 1'b1);

      tx_idle_pct = 46;
      rx_idle_pct = 19;
      run_segment(120, sui_pkg::EPS_W'($urandom), 1'b1);

      tx_idle_pct = 0;
      rx_idle_pct = 0;
      run_segment(60, sui_pkg::EPS_W'($urandom_range(0, 70000)), 1'b0);

      repeat (20) @(negedge clock);
      if (error_count == 0)
         $display("tb_top: done, clean");
      else
         $display("tb_top: done, errors");
      $finish;
   end

endmodule
